### sv/dqsr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package dqsr_pkg;

    localparam int DEPTH_DEF      = 16;
    localparam int DATA_WIDTH_DEF = 32;

    localparam int MODE_W   = 3;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;

    typedef logic [MODE_W-1:0]   t_mode;
    typedef logic [STATUS_W-1:0] t_status;

    localparam t_mode MODE_PUSH_FRONT = 3'd0;
    localparam t_mode MODE_PUSH_BACK  = 3'd1;
    localparam t_mode MODE_POP_FRONT  = 3'd2;
    localparam t_mode MODE_POP_BACK   = 3'd3;
    localparam t_mode MODE_CONTAINS   = 3'd4;
    localparam t_mode MODE_REMOVE     = 3'd5;

    localparam t_status ST_OK        = 2'd0;
    localparam t_status ST_FULL      = 2'd1;
    localparam t_status ST_EMPTY     = 2'd2;
    localparam t_status ST_NOT_FOUND = 2'd3;

    typedef struct packed {
        logic cap;
        logic exec;
        logic scan;
        logic shift;
        logic rd_ends;
        logic load;
    } t_cmd;

    typedef struct packed {
        logic search;
        logic remove;
        logic scan_end;
        logic hit;
        logic shift_done;
        logic out_free;
    } t_sts;

endpackage

`default_nettype wire

### sv/dqsr_in_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface dqsr_in_if;
    logic                          valid;
    logic                          ready;
    logic [dqsr_pkg::MODE_W-1:0]   mode;
    logic [dqsr_pkg::VALUE_W-1:0]  value;

    modport source (output valid, output mode, output value, input ready);
    modport sink   (input valid, input mode, input value, output ready);
endinterface

`default_nettype wire

### sv/dqsr_out_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface dqsr_out_if;
    logic                           valid;
    logic                           ready;
    logic [dqsr_pkg::STATUS_W-1:0]  status;
    logic                           found;
    logic [dqsr_pkg::VALUE_W-1:0]   front_value;
    logic [dqsr_pkg::VALUE_W-1:0]   back_value;
    logic [dqsr_pkg::COUNT_W-1:0]   count;
    logic                           empty_res;

    modport source (output valid, output status, output found, output front_value,
                    output back_value, output count, output empty_res, input ready);
    modport sink   (input valid, input status, input found, input front_value,
                    input back_value, input count, input empty_res, output ready);
endinterface

`default_nettype wire

### sv/dqsr_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module dqsr_datapath #(
    parameter int DEPTH      = dqsr_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = dqsr_pkg::DATA_WIDTH_DEF
) (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire dqsr_pkg::t_cmd            i_cmd,
    output dqsr_pkg::t_sts                 o_sts,
    input  wire [dqsr_pkg::MODE_W-1:0]     i_in_mode,
    input  wire [dqsr_pkg::VALUE_W-1:0]    i_in_value,
    input  wire                            i_out_ready,
    output logic                           o_out_valid,
    output logic [dqsr_pkg::STATUS_W-1:0]  o_status,
    output logic                           o_found,
    output logic [dqsr_pkg::VALUE_W-1:0]   o_front_value,
    output logic [dqsr_pkg::VALUE_W-1:0]   o_back_value,
    output logic [dqsr_pkg::COUNT_W-1:0]   o_count,
    output logic                           o_empty_res
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = AW + 1;

    function automatic logic [AW-1:0] f_slot(input logic [AW-1:0] base,
                                             input logic [CW-1:0] pos);
        logic [SW-1:0] s;
        s = SW'(base) + SW'(pos);
        if (s >= SW'(DEPTH)) begin
            s = s - SW'(DEPTH);
        end
        return s[AW-1:0];
    endfunction

    logic [DATA_WIDTH-1:0] mem [DEPTH];

    dqsr_pkg::t_mode       r_mode;
    logic [DATA_WIDTH-1:0] r_value;
    logic [AW-1:0]         r_front, n_front;
    logic [CW-1:0]         r_count, n_count;
    dqsr_pkg::t_status     r_status, n_status;
    logic                  r_found, n_found;
    logic [CW-1:0]         r_idx, n_idx;
    logic                  r_cmp_vld, n_cmp_vld;
    logic [CW-1:0]         r_cmp_idx, n_cmp_idx;
    logic                  r_wr_vld, n_wr_vld;
    logic [CW-1:0]         r_wr_pos, n_wr_pos;
    logic [DATA_WIDTH-1:0] r_rd_a, r_rd_b;
    logic                  r_out_vld, n_out_vld;

    logic [dqsr_pkg::STATUS_W-1:0] r_o_status;
    logic                          r_o_found;
    logic [dqsr_pkg::VALUE_W-1:0]  r_o_front, r_o_back;
    logic [dqsr_pkg::COUNT_W-1:0]  r_o_count;
    logic                          r_o_empty;

    logic                  full, empty, idx_live, hit, scan_end, shift_done, out_free;
    logic                  search, remove;
    logic [CW-1:0]         last_pos, pos_a;
    logic [AW-1:0]         rd_addr_a, rd_addr_b, front_dec, front_inc;
    logic                  we;
    logic [AW-1:0]         waddr;
    logic [DATA_WIDTH-1:0] wdata, v_in;

    assign v_in       = DATA_WIDTH'(i_in_value);
    assign full       = (r_count == CW'(DEPTH));
    assign empty      = (r_count == '0);
    assign last_pos   = empty ? '0 : CW'(r_count - CW'(1));
    assign idx_live   = (r_idx < r_count);
    assign hit        = r_cmp_vld && (r_rd_a == r_value);
    assign scan_end   = empty || (r_cmp_vld && (hit || (r_cmp_idx == last_pos)));
    assign shift_done = !idx_live && !r_wr_vld;
    assign out_free   = !r_out_vld || i_out_ready;
    assign search     = r_mode inside {dqsr_pkg::MODE_CONTAINS, dqsr_pkg::MODE_REMOVE};
    assign remove     = (r_mode == dqsr_pkg::MODE_REMOVE);

    assign pos_a      = ((i_cmd.scan || i_cmd.shift) && idx_live) ? r_idx : '0;
    assign rd_addr_a  = f_slot(r_front, pos_a);
    assign rd_addr_b  = f_slot(r_front, last_pos);
    assign front_dec  = (r_front == '0) ? AW'(DEPTH - 1) : AW'(r_front - AW'(1));
    assign front_inc  = f_slot(r_front, CW'(1));

    assign o_sts.search     = search;
    assign o_sts.remove     = remove;
    assign o_sts.scan_end   = scan_end;
    assign o_sts.hit        = hit;
    assign o_sts.shift_done = shift_done;
    assign o_sts.out_free   = out_free;

    // write port: pushes during exec, gap closing during shift
    always_comb begin
        we    = 1'b0;
        waddr = '0;
        wdata = r_value;
        if (i_cmd.exec && !full) begin
            case (r_mode)
                dqsr_pkg::MODE_PUSH_FRONT: begin
                    we    = 1'b1;
                    waddr = front_dec;
                end
                dqsr_pkg::MODE_PUSH_BACK: begin
                    we    = 1'b1;
                    waddr = f_slot(r_front, r_count);
                end
                default: begin
                    we = 1'b0;
                end
            endcase
        end else if (i_cmd.shift && r_wr_vld) begin
            we    = 1'b1;
            waddr = f_slot(r_front, r_wr_pos);
            wdata = r_rd_a;
        end
    end

    always_comb begin
        n_front   = r_front;
        n_count   = r_count;
        n_status  = r_status;
        n_found   = r_found;
        n_idx     = r_idx;
        n_cmp_vld = r_cmp_vld;
        n_cmp_idx = r_cmp_idx;
        n_wr_vld  = r_wr_vld;
        n_wr_pos  = r_wr_pos;
        if (i_cmd.cap) begin
            n_status  = dqsr_pkg::ST_OK;
            n_found   = 1'b0;
            n_idx     = '0;
            n_cmp_vld = 1'b0;
            n_wr_vld  = 1'b0;
        end
        if (i_cmd.exec) begin
            case (r_mode)
                dqsr_pkg::MODE_PUSH_FRONT: begin
                    if (full) begin
                        n_status = dqsr_pkg::ST_FULL;
                    end else begin
                        n_front = front_dec;
                        n_count = CW'(r_count + CW'(1));
                    end
                end
                dqsr_pkg::MODE_PUSH_BACK: begin
                    if (full) begin
                        n_status = dqsr_pkg::ST_FULL;
                    end else begin
                        n_count = CW'(r_count + CW'(1));
                    end
                end
                dqsr_pkg::MODE_POP_FRONT: begin
                    if (empty) begin
                        n_status = dqsr_pkg::ST_EMPTY;
                    end else begin
                        n_front = front_inc;
                        n_count = CW'(r_count - CW'(1));
                    end
                end
                dqsr_pkg::MODE_POP_BACK: begin
                    if (empty) begin
                        n_status = dqsr_pkg::ST_EMPTY;
                    end else begin
                        n_count = CW'(r_count - CW'(1));
                    end
                end
                default: begin
                    n_status = dqsr_pkg::ST_OK;
                end
            endcase
        end
        if (i_cmd.scan) begin
            if (idx_live) begin
                n_cmp_vld = 1'b1;
                n_cmp_idx = r_idx;
                n_idx     = CW'(r_idx + CW'(1));
            end else begin
                n_cmp_vld = 1'b0;
            end
            if (scan_end) begin
                n_found = hit;
                if (remove && !hit) begin
                    n_status = dqsr_pkg::ST_NOT_FOUND;
                end
                if (remove && hit) begin
                    n_idx     = CW'(r_cmp_idx + CW'(1));
                    n_cmp_vld = 1'b0;
                    n_wr_vld  = 1'b0;
                end
            end
        end
        if (i_cmd.shift) begin
            if (idx_live) begin
                n_wr_vld = 1'b1;
                n_wr_pos = CW'(r_idx - CW'(1));
                n_idx    = CW'(r_idx + CW'(1));
            end else begin
                n_wr_vld = 1'b0;
            end
            if (shift_done) begin
                n_count = CW'(r_count - CW'(1));
            end
        end
        n_out_vld = r_out_vld;
        if (i_cmd.load) begin
            n_out_vld = 1'b1;
        end else if (i_out_ready) begin
            n_out_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front   <= '0;
            r_count   <= '0;
            r_cmp_vld <= 1'b0;
            r_wr_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_front   <= n_front;
            r_count   <= n_count;
            r_cmp_vld <= n_cmp_vld;
            r_wr_vld  <= n_wr_vld;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_status  <= n_status;
        r_found   <= n_found;
        r_idx     <= n_idx;
        r_cmp_idx <= n_cmp_idx;
        r_wr_pos  <= n_wr_pos;
        if (i_cmd.cap) begin
            r_mode  <= i_in_mode;
            r_value <= v_in;
        end
        if (i_cmd.load) begin
            r_o_status <= r_status;
            r_o_found  <= r_found;
            r_o_front  <= empty ? '0 : dqsr_pkg::VALUE_W'(r_rd_a);
            r_o_back   <= empty ? '0 : dqsr_pkg::VALUE_W'(r_rd_b);
            r_o_count  <= dqsr_pkg::COUNT_W'(r_count);
            r_o_empty  <= empty;
        end
    end

    // entry store, one write and two registered reads
    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (i_cmd.scan || i_cmd.shift || i_cmd.rd_ends) begin
            r_rd_a <= mem[rd_addr_a];
        end
        if (i_cmd.rd_ends) begin
            r_rd_b <= mem[rd_addr_b];
        end
    end

    assign o_out_valid   = r_out_vld;
    assign o_status      = r_o_status;
    assign o_found       = r_o_found;
    assign o_front_value = r_o_front;
    assign o_back_value  = r_o_back;
    assign o_count       = r_o_count;
    assign o_empty_res   = r_o_empty;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("entry count above depth");

    a_front_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_front <= AW'(DEPTH - 1))
        else $error("front index out of range");

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load |-> (!r_out_vld || i_out_ready))
        else $error("result loaded over an untaken beat");

    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_o_empty) |-> (r_o_front == '0 && r_o_back == '0))
        else $error("empty result with nonzero ends");

    a_cmp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cmp_vld |-> (r_cmp_idx < r_count))
        else $error("compare index past live entries");

endmodule

`default_nettype wire

### sv/dqsr_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module dqsr_ctrl (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_in_valid,
    output logic                 o_in_ready,
    input  wire dqsr_pkg::t_sts  i_sts,
    output dqsr_pkg::t_cmd       o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_SCAN,
        S_SHIFT,
        S_READ,
        S_LOAD
    } t_state;

    t_state r_state, n_state;
    logic   r_in_rdy, n_in_rdy;

    always_comb begin
        o_cmd    = '0;
        n_state  = r_state;
        n_in_rdy = r_in_rdy;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid && r_in_rdy) begin
                    o_cmd.cap = 1'b1;
                    n_in_rdy  = 1'b0;
                    n_state   = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = i_sts.search ? S_SCAN : S_READ;
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_sts.scan_end) begin
                    n_state = (i_sts.remove && i_sts.hit) ? S_SHIFT : S_READ;
                end
            end
            S_SHIFT: begin
                o_cmd.shift = 1'b1;
                if (i_sts.shift_done) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                o_cmd.rd_ends = 1'b1;
                n_state       = S_LOAD;
            end
            S_LOAD: begin
                if (i_sts.out_free) begin
                    o_cmd.load = 1'b1;
                    n_in_rdy   = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state  = S_IDLE;
                n_in_rdy = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_in_rdy <= 1'b1;
        end else begin
            r_state  <= n_state;
            r_in_rdy <= n_in_rdy;
        end
    end

    assign o_in_ready = r_in_rdy;

endmodule

`default_nettype wire

### sv/deque_with_search_remove_top.sv
`timescale 1ns / 1ps
`default_nettype none

// Bounded double-ended queue of up to DEPTH values with push and pop at either
// end, a membership query and remove-first-match that closes the gap. Every
// input beat gives exactly one result beat carrying status, found flag, front
// and back values, count and an empty flag. Items are handled one at a time
// through a walk of the entry memory: push, pop and unused modes pass through
// the exec, read and load states before the next accept; contains walks the
// stored entries in a scan state, one stored entry compared per cycle; remove
// then closes the gap in a shift state, one entry moved per cycle. The result
// sits in an output register, so a stalled sink only holds the next item once
// it is ready to be loaded. The entry memory is not cleared after reset.
module deque_with_search_remove_top #(
    parameter int DEPTH      = dqsr_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = dqsr_pkg::DATA_WIDTH_DEF
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    dqsr_in_if.sink     i_in,
    dqsr_out_if.source  o_out
);

    dqsr_pkg::t_cmd cmd;
    dqsr_pkg::t_sts sts;

    dqsr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    dqsr_datapath #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_in_mode     (i_in.mode),
        .i_in_value    (i_in.value),
        .i_out_ready   (o_out.ready),
        .o_out_valid   (o_out.valid),
        .o_status      (o_out.status),
        .o_found       (o_out.found),
        .o_front_value (o_out.front_value),
        .o_back_value  (o_out.back_value),
        .o_count       (o_out.count),
        .o_empty_res   (o_out.empty_res)
    );

endmodule

`default_nettype wire

### sim/tb.sv
`timescale 1ns / 1ps

module tb;

    localparam int QDEPTH = dqsr_pkg::DEPTH_DEF;

    localparam dqsr_pkg::t_mode MODE_SPARE_A = 3'd6;
    localparam dqsr_pkg::t_mode MODE_SPARE_B = 3'd7;

    localparam int FILL  = 0;
    localparam int DRAIN = 1;
    localparam int HUNT  = 2;

    typedef struct packed {
        dqsr_pkg::t_mode op;
        logic [31:0]     val;
    } t_deque_op;

    typedef struct packed {
        dqsr_pkg::t_status status;
        logic              found;
        logic [31:0]       front_value;
        logic [31:0]       back_value;
        logic [4:0]        count;
        logic              empty_res;
    } t_deque_view;

    logic i_clk = 1'b0;
    logic i_rst_n;

    dqsr_in_if  in_bus();
    dqsr_out_if out_bus();

    deque_with_search_remove_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_bus),
        .o_out   (out_bus)
    );

    // shadow deque
    logic [31:0] dq_mem [QDEPTH];
    logic [3:0]  dq_head = 4'd0;
    logic [4:0]  dq_cnt = 5'd0;

    t_deque_op   ops_to_send [$];
    t_deque_view awaited_views [$];
    t_deque_op   op_in_flight;
    logic [31:0] val_pool [6];

    int n_items;
    int ops_sent = 0;
    int views_seen = 0;
    int err_count = 0;
    int src_gap = 0;
    int snk_gap = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic logic [3:0] slot_at(int pos);
        return dq_head + pos[3:0];
    endfunction

    task automatic deque_apply(input dqsr_pkg::t_mode op, input logic [31:0] val);
        t_deque_view v;
        int          hit;
        int          j;
        v = '0;
        hit = -1;
        v.status = dqsr_pkg::ST_OK;
        case (op)
            dqsr_pkg::MODE_PUSH_FRONT, dqsr_pkg::MODE_PUSH_BACK: begin
                if (dq_cnt == QDEPTH) begin
                    v.status = dqsr_pkg::ST_FULL;
                end else if (op == dqsr_pkg::MODE_PUSH_FRONT) begin
                    dq_head = dq_head - 4'd1;
                    dq_mem[dq_head] = val;
                    dq_cnt = dq_cnt + 5'd1;
                end else begin
                    dq_mem[slot_at(dq_cnt)] = val;
                    dq_cnt = dq_cnt + 5'd1;
                end
            end
            dqsr_pkg::MODE_POP_FRONT, dqsr_pkg::MODE_POP_BACK: begin
                if (dq_cnt == 0) begin
                    v.status = dqsr_pkg::ST_EMPTY;
                end else begin
                    if (op == dqsr_pkg::MODE_POP_FRONT) dq_head = dq_head + 4'd1;
                    dq_cnt = dq_cnt - 5'd1;
                end
            end
            dqsr_pkg::MODE_CONTAINS, dqsr_pkg::MODE_REMOVE: begin
                for (j = 0; j < dq_cnt && hit < 0; j++) begin
                    if (dq_mem[slot_at(j)] == val) hit = j;
                end
                v.found = (hit >= 0);
                if (op == dqsr_pkg::MODE_REMOVE) begin
                    if (hit < 0) begin
                        v.status = dqsr_pkg::ST_NOT_FOUND;
                    end else begin
                        for (j = hit; j + 1 < dq_cnt; j++)
                            dq_mem[slot_at(j)] = dq_mem[slot_at(j + 1)];
                        dq_cnt = dq_cnt - 5'd1;
                    end
                end
            end
            default: ;
        endcase
        if (dq_cnt != 0) begin
            v.front_value = dq_mem[slot_at(0)];
            v.back_value  = dq_mem[slot_at(dq_cnt - 1)];
        end
        v.count     = dq_cnt;
        v.empty_res = (dq_cnt == 0);
        awaited_views.push_back(v);
    endtask

    task automatic queue_op(input dqsr_pkg::t_mode op, input logic [31:0] val);
        t_deque_op o;
        o.op  = op;
        o.val = val;
        ops_to_send.push_back(o);
    endtask

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 11))
            0: return $urandom();
            1: return 32'h0;
            2: return 32'hFFFF_FFFF;
            default: return val_pool[$urandom_range(0, 5)];
        endcase
    endfunction

    // input driver
    always @(posedge i_clk) begin : drive_in
        logic load;
        logic idle_ok;
        load = 1'b0;
        idle_ok = (ops_sent < n_items - 80) && ((ops_sent / 64) % 3 != 2);
        if (!i_rst_n) begin
            in_bus.valid <= 1'b0;
            in_bus.mode  <= dqsr_pkg::MODE_PUSH_FRONT;
            in_bus.value <= 32'h0;
        end else begin
            if (in_bus.valid && in_bus.ready) begin
                deque_apply(op_in_flight.op, op_in_flight.val);
                ops_sent++;
            end
            if (!in_bus.valid || in_bus.ready) begin
                if (src_gap > 0) begin
                    src_gap--;
                end else if (idle_ok && $urandom_range(0, 11) == 0) begin
                    src_gap = $urandom_range(0, 15);
                end else if (ops_to_send.size() != 0) begin
                    op_in_flight = ops_to_send.pop_front();
                    load = 1'b1;
                end
                in_bus.valid <= load;
                if (load) begin
                    in_bus.mode  <= op_in_flight.op;
                    in_bus.value <= op_in_flight.val;
                end
            end
        end
    end

    // result monitor
    always @(posedge i_clk) begin : watch_out
        t_deque_view got;
        t_deque_view want;
        logic        idle_ok;
        idle_ok = (views_seen < n_items - 80) && ((views_seen / 48) % 3 != 1);
        got.status      = out_bus.status;
        got.found       = out_bus.found;
        got.front_value = out_bus.front_value;
        got.back_value  = out_bus.back_value;
        got.count       = out_bus.count;
        got.empty_res   = out_bus.empty_res;
        if (!i_rst_n) begin
            out_bus.ready <= 1'b0;
        end else begin
            if (out_bus.valid && out_bus.ready) begin
                views_seen++;
                if (awaited_views.size() == 0) begin
                    if (err_count < 10)
                        $display("%0t: result beat with nothing pending: st=%0d found=%0d",
                                 $realtime, got.status, got.found);
                    err_count++;
                end else begin
                    want = awaited_views.pop_front();
                    if (got !== want) begin
                        if (err_count < 10) begin
                            $display("%0t: beat %0d mismatch", $realtime, views_seen);
                            $display("  exp st=%0d found=%0d front=%h back=%h cnt=%0d empty=%0d",
                                     want.status, want.found, want.front_value,
                                     want.back_value, want.count, want.empty_res);
                            $display("  got st=%0d found=%0d front=%h back=%h cnt=%0d empty=%0d",
                                     got.status, got.found, got.front_value,
                                     got.back_value, got.count, got.empty_res);
                        end
                        err_count++;
                    end
                end
            end
            if (snk_gap > 0) begin
                snk_gap--;
                out_bus.ready <= 1'b0;
            end else if (idle_ok && $urandom_range(0, 9) == 0) begin
                snk_gap = $urandom_range(0, 15);
                out_bus.ready <= 1'b0;
            end else begin
                out_bus.ready <= 1'b1;
            end
        end
    end

    initial begin
        int              k;
        int              seg_kind;
        int              seg_len;
        int              roll;
        int              p_push;
        int              p_pop;
        int              p_find;
        dqsr_pkg::t_mode op;
        i_rst_n = 1'b0;

        // empty queue corners, ends, duplicates, spare modes
        queue_op(dqsr_pkg::MODE_POP_FRONT, 32'h1234_5678);
        queue_op(dqsr_pkg::MODE_POP_BACK, 32'h0);
        queue_op(dqsr_pkg::MODE_CONTAINS, 32'h0);
        queue_op(dqsr_pkg::MODE_REMOVE, 32'h0);
        queue_op(MODE_SPARE_A, 32'hFFFF_FFFF);
        queue_op(dqsr_pkg::MODE_PUSH_FRONT, 32'h0);
        queue_op(dqsr_pkg::MODE_PUSH_BACK, 32'hFFFF_FFFF);
        queue_op(dqsr_pkg::MODE_PUSH_FRONT, 32'h8000_0000);
        queue_op(dqsr_pkg::MODE_PUSH_BACK, 32'h0000_0001);
        queue_op(dqsr_pkg::MODE_PUSH_BACK, 32'h0);
        queue_op(dqsr_pkg::MODE_CONTAINS, 32'hFFFF_FFFF);
        queue_op(dqsr_pkg::MODE_CONTAINS, 32'h1234_5678);
        queue_op(dqsr_pkg::MODE_REMOVE, 32'h0);
        queue_op(dqsr_pkg::MODE_REMOVE, 32'h8000_0000);
        queue_op(dqsr_pkg::MODE_REMOVE, 32'h0);
        queue_op(dqsr_pkg::MODE_REMOVE, 32'h0000_0055);
        queue_op(dqsr_pkg::MODE_POP_BACK, 32'h0);
        queue_op(MODE_SPARE_B, 32'h7FFF_FFFF);
        queue_op(dqsr_pkg::MODE_POP_FRONT, 32'h0);
        queue_op(dqsr_pkg::MODE_POP_FRONT, 32'h0);
        queue_op(dqsr_pkg::MODE_POP_BACK, 32'h0);

        // fill past full, then drain past empty
        for (k = 0; k < QDEPTH + 2; k++)
            queue_op($urandom_range(0, 1) ? dqsr_pkg::MODE_PUSH_FRONT
                                          : dqsr_pkg::MODE_PUSH_BACK, $urandom());
        for (k = 0; k < QDEPTH + 2; k++)
            queue_op($urandom_range(0, 1) ? dqsr_pkg::MODE_POP_FRONT
                                          : dqsr_pkg::MODE_POP_BACK, $urandom());

        while (ops_to_send.size() < 525) begin
            seg_kind = $urandom_range(FILL, HUNT);
            seg_len = $urandom_range(15, 50);
            for (k = 0; k < 6; k++)
                val_pool[k] = $urandom_range(0, 3) == 0 ? $urandom() : $urandom_range(0, 7);
            case (seg_kind)
                FILL:    begin p_push = 75; p_pop = 8;  p_find = 8;  end
                DRAIN:   begin p_push = 12; p_pop = 68; p_find = 10; end
                default: begin p_push = 35; p_pop = 12; p_find = 24; end
            endcase
            for (k = 0; k < seg_len; k++) begin
                roll = $urandom_range(0, 99);
                if (roll < p_push)
                    op = $urandom_range(0, 1) ? dqsr_pkg::MODE_PUSH_FRONT
                                              : dqsr_pkg::MODE_PUSH_BACK;
                else if (roll < p_push + p_pop)
                    op = $urandom_range(0, 1) ? dqsr_pkg::MODE_POP_FRONT
                                              : dqsr_pkg::MODE_POP_BACK;
                else if (roll < p_push + p_pop + p_find)
                    op = dqsr_pkg::MODE_CONTAINS;
                else if (roll < 98)
                    op = dqsr_pkg::MODE_REMOVE;
                else
                    op = $urandom_range(0, 1) ? MODE_SPARE_A : MODE_SPARE_B;
                queue_op(op, pick_value());
            end
        end
        n_items = ops_to_send.size();

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        do @(posedge i_clk);
        while (ops_to_send.size() != 0 || in_bus.valid || awaited_views.size() != 0);
        repeat (60) @(posedge i_clk);

        if (err_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

### sim.f
sv/dqsr_pkg.sv
sv/dqsr_in_if.sv
sv/dqsr_out_if.sv
sv/dqsr_datapath.sv
sv/dqsr_ctrl.sv
sv/deque_with_search_remove_top.sv
sim/tb.sv
